// ===== rtl/bilinear_plane_scaler_top_macros.svh =====
// assertion helpers for the bilinear plane scaler
`ifndef BILINEAR_PLANE_SCALER_TOP_MACROS_SVH
`define BILINEAR_PLANE_SCALER_TOP_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define BPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bilinear plane scaler check failed");

// next-cycle implication
`define BPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bilinear plane scaler check failed");

`endif

// ===== rtl/bps_pkg.sv =====
package bps_pkg;

  localparam int unsigned MaxLine    = 2048;
  localparam int unsigned MaxUpscale = 4;
  localparam int unsigned MinStep    = 65536 / MaxUpscale;
  localparam int unsigned LineAw     = $clog2(MaxLine);

  // configuration register indexes
  localparam logic [2:0] CFG_SRC_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_SRC_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_DST_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_DST_HEIGHT = 3'd3;
  localparam logic [2:0] CFG_X_STEP     = 3'd4;
  localparam logic [2:0] CFG_Y_STEP     = 3'd5;

  typedef struct packed {
    logic [7:0] pixel;
    logic       plane_start;
  } pix_in_t;

  typedef struct packed {
    logic [13:0] out_row;
    logic [12:0] out_col;
    logic [7:0]  value;
    logic        last;
  } pix_out_t;

endpackage

// ===== rtl/bps_in_if.sv =====
interface bps_in_if;
  import bps_pkg::*;

  logic    valid;
  logic    ready;
  pix_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/bps_out_if.sv =====
interface bps_out_if;
  import bps_pkg::*;

  logic     valid;
  logic     ready;
  pix_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/bilinear_plane_scaler_top.sv =====
// sequence: accept, column scan (S_SCOL), row scan (S_SROW), then per result S_RD, S_MUL1,
//   S_MUL2, and finally close (S_FIN); the scans cover the destination columns / rows that
//   the pixel completes, and a pixel with no result goes from the scans straight to close
// input: a new pixel is taken only in S_IDLE; results stall on the output register only
// reset: config registers take their default sizes, source and pending position counters clear,
//   line buffers are not cleared and hold nothing valid until written
`include "bilinear_plane_scaler_top_macros.svh"

module bilinear_plane_scaler_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [28:0] cfg_data_i,
  bps_in_if.sink      in_i,
  bps_out_if.source   out_o
);
  import bps_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCOL = 3'd1;
  localparam logic [2:0] S_SROW = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_MUL1 = 3'd4;
  localparam logic [2:0] S_MUL2 = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [11:0] src_width_q;
  logic [12:0] src_height_q;
  logic [13:0] dst_width_q;
  logic [14:0] dst_height_q;
  logic [27:0] x_step_q;
  logic [28:0] y_step_q;

  logic [2:0]  state_q;
  logic [11:0] src_row_q;
  logic [10:0] src_col_q;
  logic [14:0] pend_row_q;
  logic [13:0] pend_col_q;
  logic        lsel_q;

  logic [13:0] it_col_q;
  logic [41:0] it_xpos_q;
  logic [14:0] it_row_q;
  logic [43:0] it_ypos_q;
  logic [13:0] col_end_q;
  logic [14:0] row_end_q;

  logic [14:0] em_row_q;
  logic [43:0] em_ypos_q;
  logic [13:0] em_col_q;
  logic [41:0] em_xpos_q;
  logic [5:0]  n_q;

  logic [15:0] fx_q;
  logic [15:0] fy_q;
  logic        y0_low_q;
  logic        y1_low_q;
  logic [23:0] top_q;
  logic [23:0] bot_q;

  logic       out_valid_q;
  pix_out_t   out_data_q;

  logic [7:0] mem0 [MaxLine];
  logic [7:0] mem1 [MaxLine];
  logic [7:0] m0_a_q, m0_b_q, m1_a_q, m1_b_q;

  // effective sizes and steps
  logic [11:0] sw;
  logic [12:0] sh;
  logic [13:0] dw;
  logic [14:0] dh;
  logic [27:0] xs;
  logic [28:0] ys;

  always_comb begin
    if (src_width_q == 12'd0) sw = 12'd1;
    else if (src_width_q > 12'(MaxLine)) sw = 12'(MaxLine);
    else sw = src_width_q;
    if (src_height_q == 13'd0) sh = 13'd1;
    else if (src_height_q > 13'd4096) sh = 13'd4096;
    else sh = src_height_q;
    dw = (dst_width_q > 14'd8192) ? 14'd8192 : dst_width_q;
    dh = (dst_height_q > 15'd16384) ? 15'd16384 : dst_height_q;
    xs = (x_step_q < 28'(MinStep)) ? 28'(MinStep) : x_step_q;
    ys = (y_step_q < 29'(MinStep)) ? 29'(MinStep) : y_step_q;
  end

  // source positions of the first unfinished destination column and row
  logic [41:0] col_pos;
  logic [43:0] row_pos;
  assign col_pos = {28'd0, pend_col_q} * {14'd0, xs};
  assign row_pos = {29'd0, pend_row_q} * {15'd0, ys};

  logic in_acc;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  // completeness of the scanned column and row
  logic [25:0] sx0, sx0_p1, sx1;
  logic [27:0] sy0, sy0_p1, sy1;
  logic        col_ok, row_ok;

  always_comb begin
    sx0    = it_xpos_q[41:16];
    sx0_p1 = sx0 + 26'd1;
    sx1    = (sx0_p1 >= {14'd0, sw}) ? sx0 : sx0_p1;
    col_ok = (it_col_q < dw) && (sx0 < {14'd0, sw}) && (sx1 <= {15'd0, src_col_q});
    sy0    = it_ypos_q[43:16];
    sy0_p1 = sy0 + 28'd1;
    sy1    = (sy0_p1 >= {15'd0, sh}) ? sy0 : sy0_p1;
    row_ok = (it_row_q < dh) && (sy0 < {15'd0, sh}) && (sy1 <= {16'd0, src_row_q});
  end

  // neighborhood of the destination pixel being emitted
  logic [25:0] ex0, ex0_p1, ex1;
  logic [27:0] ey0, ey0_p1, ey1;

  always_comb begin
    ex0    = em_xpos_q[41:16];
    ex0_p1 = ex0 + 26'd1;
    ex1    = (ex0_p1 >= {14'd0, sw}) ? ex0 : ex0_p1;
    ey0    = em_ypos_q[43:16];
    ey0_p1 = ey0 + 28'd1;
    ey1    = (ey0_p1 >= {15'd0, sh}) ? ey0 : ey0_p1;
  end

  // line buffers, ping-pong: lsel_q names the one holding the current row
  logic [LineAw-1:0] wr_addr;
  assign wr_addr = in_i.data.plane_start ? '0 : src_col_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && !lsel_q) mem0[wr_addr] <= in_i.data.pixel;
    if (state_q == S_RD) begin
      m0_a_q <= mem0[ex0[LineAw-1:0]];
      m0_b_q <= mem0[ex1[LineAw-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && lsel_q) mem1[wr_addr] <= in_i.data.pixel;
    if (state_q == S_RD) begin
      m1_a_q <= mem1[ex0[LineAw-1:0]];
      m1_b_q <= mem1[ex1[LineAw-1:0]];
    end
  end

  // horizontal blend: a*65536 + fx*(b - a)
  logic [7:0]         lo_a, lo_b, up_a, up_b, p00, p01, p10, p11;
  logic signed [8:0]  dt, db;
  logic signed [25:0] mt, mb, st, sb;

  always_comb begin
    lo_a = lsel_q ? m1_a_q : m0_a_q;
    lo_b = lsel_q ? m1_b_q : m0_b_q;
    up_a = lsel_q ? m0_a_q : m1_a_q;
    up_b = lsel_q ? m0_b_q : m1_b_q;
    p00  = y0_low_q ? lo_a : up_a;
    p01  = y0_low_q ? lo_b : up_b;
    p10  = y1_low_q ? lo_a : up_a;
    p11  = y1_low_q ? lo_b : up_b;
    dt   = $signed({1'b0, p01}) - $signed({1'b0, p00});
    db   = $signed({1'b0, p11}) - $signed({1'b0, p10});
    mt   = $signed({1'b0, fx_q}) * dt;
    mb   = $signed({1'b0, fx_q}) * db;
    st   = $signed({2'b00, p00, 16'd0}) + mt;
    sb   = $signed({2'b00, p10, 16'd0}) + mb;
  end

  // vertical blend: top*65536 + fy*(bot - top), keep bits 39:32
  logic signed [24:0] dv;
  logic signed [41:0] mv;
  logic signed [42:0] acc;
  logic [7:0]         val;

  always_comb begin
    dv  = $signed({1'b0, bot_q}) - $signed({1'b0, top_q});
    mv  = $signed({1'b0, fy_q}) * dv;
    acc = $signed({3'b000, top_q, 16'd0}) + 43'(mv);
    val = acc[39:32];
  end

  logic nxt_col, nxt_row, is_last, out_free;
  assign nxt_col  = ({1'b0, em_col_q} + 15'd1) < {1'b0, col_end_q};
  assign nxt_row  = ({1'b0, em_row_q} + 16'd1) < {1'b0, row_end_q};
  assign is_last  = (n_q == 6'd63) || (!nxt_col && !nxt_row);
  assign out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= 12'd2048;
      src_height_q <= 13'd4096;
      dst_width_q  <= 14'd2048;
      dst_height_q <= 15'd4096;
      x_step_q     <= 28'd65536;
      y_step_q     <= 29'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SRC_WIDTH:  src_width_q  <= cfg_data_i[11:0];
        CFG_SRC_HEIGHT: src_height_q <= cfg_data_i[12:0];
        CFG_DST_WIDTH:  dst_width_q  <= cfg_data_i[13:0];
        CFG_DST_HEIGHT: dst_height_q <= cfg_data_i[14:0];
        CFG_X_STEP:     x_step_q     <= cfg_data_i[27:0];
        CFG_Y_STEP:     y_step_q     <= cfg_data_i[28:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      src_row_q   <= '0;
      src_col_q   <= '0;
      pend_row_q  <= '0;
      pend_col_q  <= '0;
      lsel_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready && (state_q != S_MUL2)) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (in_i.data.plane_start) begin
              src_row_q  <= '0;
              src_col_q  <= '0;
              pend_row_q <= '0;
              pend_col_q <= '0;
            end
            state_q <= S_SCOL;
          end
        end
        S_SCOL: begin
          if (!col_ok) state_q <= S_SROW;
        end
        S_SROW: begin
          if (!row_ok) begin
            if ((pend_row_q < it_row_q) && (pend_col_q < col_end_q)) state_q <= S_RD;
            else state_q <= S_FIN;
          end
        end
        S_RD:   state_q <= S_MUL1;
        S_MUL1: state_q <= S_MUL2;
        S_MUL2: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= is_last ? S_FIN : S_RD;
          end
        end
        S_FIN: begin
          pend_col_q <= col_end_q;
          if (({1'b0, src_col_q} + 12'd1) >= sw) begin
            // row done: the current line becomes the upper one
            lsel_q     <= !lsel_q;
            pend_col_q <= '0;
            src_col_q  <= '0;
            if (({1'b0, src_row_q} + 13'd1) >= sh) begin
              src_row_q  <= '0;
              pend_row_q <= '0;
            end else begin
              src_row_q  <= src_row_q + 12'd1;
              pend_row_q <= row_end_q;
            end
          end else begin
            src_col_q <= src_col_q + 11'd1;
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // scan and emission datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        it_col_q  <= in_i.data.plane_start ? '0 : pend_col_q;
        it_xpos_q <= in_i.data.plane_start ? '0 : col_pos;
      end
      S_SCOL: begin
        if (col_ok) begin
          it_col_q  <= it_col_q + 14'd1;
          it_xpos_q <= it_xpos_q + {14'd0, xs};
        end else begin
          col_end_q <= it_col_q;
          it_row_q  <= pend_row_q;
          it_ypos_q <= row_pos;
        end
      end
      S_SROW: begin
        if (row_ok) begin
          it_row_q  <= it_row_q + 15'd1;
          it_ypos_q <= it_ypos_q + {15'd0, ys};
        end else begin
          row_end_q <= it_row_q;
          em_row_q  <= pend_row_q;
          em_ypos_q <= row_pos;
          em_col_q  <= pend_col_q;
          em_xpos_q <= col_pos;
          n_q       <= '0;
        end
      end
      S_RD: begin
        fx_q     <= em_xpos_q[15:0];
        fy_q     <= em_ypos_q[15:0];
        y0_low_q <= ey0 >= {16'd0, src_row_q};
        y1_low_q <= ey1 >= {16'd0, src_row_q};
      end
      S_MUL1: begin
        top_q <= st[23:0];
        bot_q <= sb[23:0];
      end
      S_MUL2: begin
        if (out_free) begin
          out_data_q.out_row <= em_row_q[13:0];
          out_data_q.out_col <= em_col_q[12:0];
          out_data_q.value   <= val;
          out_data_q.last    <= is_last;
          n_q                <= n_q + 6'd1;
          if (nxt_col) begin
            em_col_q  <= em_col_q + 14'd1;
            em_xpos_q <= em_xpos_q + {14'd0, xs};
          end else begin
            em_row_q  <= em_row_q + 15'd1;
            em_ypos_q <= em_ypos_q + {15'd0, ys};
            em_col_q  <= pend_col_q;
            em_xpos_q <= col_pos;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  `BPS_ASSERT_NEXT(a_accept_scans, in_acc, state_q == S_SCOL)
  `BPS_ASSERT_NEXT(a_load_only_mul2, (state_q != S_MUL2) && !out_valid_q, !out_valid_q)
  `BPS_ASSERT_NOW(a_busy_until_last, out_valid_q && !out_data_q.last, state_q != S_IDLE)

endmodule
